[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros for the phaser block
// checks are clocked on clk and held off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PHSR_ASSERT_SAME(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("phaser check failed");

// consequent must hold in the cycle after the antecedent
`define PHSR_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("phaser check failed");

`endif

[hdl/phsr_pkg.sv]
// ---------------------------------------------------------------------------
// phsr_pkg
// shared types, register codes, constants and fixed-point helpers
// ---------------------------------------------------------------------------
package phsr_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_ENABLED       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DELAY_MIN     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DELAY_MAX     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LFO_STEP      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX       = 3'd5;

	// register reset values
	localparam logic [15:0] RST_DELAY_MIN     = 16'd1092;
	localparam logic [15:0] RST_DELAY_MAX     = 16'd9284;
	localparam logic [31:0] RST_LFO_STEP      = 32'd8948;
	localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd45875;
	localparam logic [16:0] RST_WET_MIX       = 17'd19661;

	// fixed-point constants
	localparam logic [16:0] ONE_Q16   = 17'd65536;
	localparam logic [16:0] OUT_SCALE = 17'd52429;   // 0.8 in Q0.16
	localparam logic [20:0] SINE_AMP2 = 21'd1048544; // 2 * 16 * 32767
	localparam int          DIV_QW    = 17;          // quotient bits of the divider

	typedef struct packed {
		logic        enabled;
		logic [15:0] delay_min;
		logic [15:0] delay_max;
		logic [31:0] lfo_step;
		logic [15:0] feedback_gain;
		logic [16:0] wet_mix;
	} cfg_t;

	typedef struct packed {
		logic filling;
		logic idle;
	} stat_t;

	typedef enum logic [4:0] {
		ST_FILL_A,
		ST_FILL_B,
		ST_FILL_W,
		ST_IDLE,
		ST_ROM,
		ST_D1,
		ST_D2,
		ST_DS,
		ST_DW,
		ST_FB1,
		ST_FB2,
		ST_AP_RD,
		ST_AP_Y,
		ST_AP_M,
		ST_AP_WB,
		ST_MIX1,
		ST_MIX2,
		ST_MIX3,
		ST_MIX4,
		ST_MIX5,
		ST_FIN
	} state_t;

	localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
	localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

	// saturate to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// round half up and drop 16 fraction bits
	function automatic logic signed [35:0] rnd16(input logic signed [51:0] p);
		logic signed [51:0] t;
		t = p + 52'sd32768;
		return t[51:16];
	endfunction

	// rounded and saturated Q.16 product
	function automatic logic signed [31:0] mulq16(input logic signed [51:0] p);
		return sat32(rnd16(p));
	endfunction

	function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [35:0] s;
		s = 36'(a) + 36'(b);
		return sat32(s);
	endfunction

	function automatic logic signed [31:0] sub_sat32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [35:0] s;
		s = 36'(a) - 36'(b);
		return sat32(s);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
		logic signed [15:0] r;
		if (v > 28'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -28'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[hdl/phsr_ram.sv]
// ---------------------------------------------------------------------------
// phsr_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module phsr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/phsr_div.sv]
// ---------------------------------------------------------------------------
// phsr_div
// restoring divider, one quotient bit per cycle, quotient must fit QW bits
// ---------------------------------------------------------------------------
module phsr_div #(
	parameter int NW = 34,
	parameter int DW = 18,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] numer,
	input  logic [DW-1:0] denom,
	output logic          done,
	output logic [QW-1:0] quotient
);

	localparam int SHW = DW + QW - 1;
	localparam int RW  = (NW > SHW) ? NW : SHW;
	localparam int CW  = $clog2(QW + 1);

	logic [RW-1:0]  rem_q;
	logic [SHW-1:0] dsh_q;
	logic [QW-1:0]  quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [RW:0]    diff;
	logic           take;

	// trial subtract of the shifted divisor
	assign diff = {1'b0, rem_q} - {1'b0, RW'(dsh_q)};
	assign take = ~diff[RW];

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - CW'(1);
				busy_q <= (cnt_q != CW'(1));
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(numer);
			dsh_q <= {denom, {(QW-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= diff[RW-1:0];
			end
			quo_q <= {quo_q[QW-2:0], take};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/phsr_core.sv]
// ---------------------------------------------------------------------------
// phsr_core
// sequencer: sine table fill, lfo, coefficient divide, allpass walk, mix
// ---------------------------------------------------------------------------
module phsr_core #(
	parameter int STAGES          = 6,
	parameter int SINE_TABLE_SIZE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  phsr_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample_out,
	output phsr_pkg::stat_t    stat
);

	localparam int N   = SINE_TABLE_SIZE;
	localparam int RAW = $clog2(N + 1);
	localparam int MAW = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int QW  = phsr_pkg::DIV_QW;
	localparam int NW  = (2*RAW + 19 > 34) ? 2*RAW + 19 : 34;
	localparam int DW  = (2*RAW + 4 > 18) ? 2*RAW + 4 : 18;
	localparam int PW  = 33 + RAW;

	localparam logic [RAW-1:0] N_A       = RAW'(N);
	localparam logic [DW-1:0]  FIVE_N2   = DW'(5*N*N);
	localparam logic [MAW-1:0] LAST_STG  = MAW'(STAGES - 1);

	phsr_pkg::state_t state_q, state_d;

	// control registers
	logic [RAW-1:0]    k_q;
	logic [MAW-1:0]    n_q;
	logic [31:0]       phase_q;
	logic signed [31:0] last_q;
	logic [STAGES-1:0] mv_q;
	logic              mv_rd_q;
	logic              out_valid_q;

	// datapath registers
	logic [2*RAW-1:0]   q_q;
	logic               neg_q;
	logic signed [15:0] sample_q;
	logic [15:0]        frac_q;
	logic [32:0]        plo_q;
	logic [31:0]        phi_q;
	logic [15:0]        d_q;
	logic signed [17:0] coef_q;
	logic signed [51:0] prod_q;
	logic signed [51:0] p1_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [33:0] mix_q;
	logic signed [15:0] res_q;
	logic signed [15:0] sample_out_q;

	// control outputs of the sequencer
	logic accept;
	logic div_start;
	logic rom_we;
	logic mem_we;
	logic out_load;

	// memories and divider wiring
	logic [15:0]     rom_rdata;
	logic [15:0]     rom_wdata;
	logic [RAW-1:0]  rom_raddr;
	logic [31:0]     mem_rdata;
	logic signed [31:0] mem_val;
	logic signed [31:0] mem_wdata;
	logic [NW-1:0]   div_numer;
	logic [DW-1:0]   div_denom;
	logic            div_done;
	logic [QW-1:0]   div_quo;

	// combinational datapath terms
	logic [PW-1:0]      idx_prod;
	logic [RAW-1:0]     idx;
	logic [RAW:0]       a_w;
	logic [RAW-1:0]     a_adj;
	logic [DW-1:0]      den_w;
	logic [15:0]        frac_w;
	logic [33:0]        dsum;
	logic [16:0]        w_clip;
	logic [16:0]        w_inv;
	logic signed [23:0] x8;
	logic signed [31:0] x8_32;
	logic signed [35:0] mix_w;
	logic signed [51:0] out_t;

	// lfo table index, rounded and clamped
	assign idx_prod  = ({{(RAW+1){1'b0}}, phase_q} * PW'(N)) + PW'(33'h080000000);
	assign idx       = idx_prod[32 +: RAW];
	assign rom_raddr = (idx > N_A) ? N_A : idx;

	// sine entry terms during fill
	assign a_w   = {k_q, 1'b0};
	assign a_adj = (a_w > {1'b0, N_A}) ? RAW'(a_w - {1'b0, N_A}) : a_w[RAW-1:0];
	assign den_w = FIVE_N2 - DW'({q_q, 2'b00});

	// sweep and mix terms
	assign frac_w = {~rom_rdata[15], rom_rdata[14:0]};
	assign dsum   = {1'b0, plo_q} + {2'b00, phi_q} + 34'd32768;
	assign w_clip = (cfg.wet_mix > phsr_pkg::ONE_Q16) ? phsr_pkg::ONE_Q16 : cfg.wet_mix;
	assign w_inv  = phsr_pkg::ONE_Q16 - w_clip;
	assign x8     = {sample_q, 8'h00};
	assign x8_32  = 32'(x8);
	assign mix_w  = phsr_pkg::rnd16(p1_q + prod_q);
	assign out_t  = prod_q + 52'sd8388608;

	// stage memory entries never written read as zero
	assign mem_val   = mv_rd_q ? $signed(mem_rdata) : 32'sd0;
	assign mem_wdata = phsr_pkg::add_sat32(phsr_pkg::mulq16(prod_q), x_q);
	assign rom_wdata = neg_q ? 16'(16'd0 - div_quo[15:0]) : div_quo[15:0];

	// divider operands: sine entry or allpass coefficient
	always_comb begin
		if (state_q == phsr_pkg::ST_DS) begin
			div_numer = NW'({(phsr_pkg::ONE_Q16 - {1'b0, d_q}), 17'h00000})
				+ NW'(phsr_pkg::ONE_Q16 + {1'b0, d_q});
			div_denom = DW'({(phsr_pkg::ONE_Q16 + {1'b0, d_q}), 1'b0});
		end else begin
			div_numer = (NW'(q_q) * NW'(phsr_pkg::SINE_AMP2)) + NW'(den_w);
			div_denom = {den_w[DW-2:0], 1'b0};
		end
	end

	// sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		div_start = 1'b0;
		rom_we    = 1'b0;
		mem_we    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			phsr_pkg::ST_FILL_A: state_d = phsr_pkg::ST_FILL_B;
			phsr_pkg::ST_FILL_B: begin
				div_start = 1'b1;
				state_d   = phsr_pkg::ST_FILL_W;
			end
			phsr_pkg::ST_FILL_W: begin
				if (div_done) begin
					rom_we  = 1'b1;
					state_d = (k_q == N_A) ? phsr_pkg::ST_IDLE : phsr_pkg::ST_FILL_A;
				end
			end
			phsr_pkg::ST_IDLE: begin
				accept = in_valid;
				if (in_valid) begin
					state_d = cfg.enabled ? phsr_pkg::ST_ROM : phsr_pkg::ST_FIN;
				end
			end
			phsr_pkg::ST_ROM: state_d = phsr_pkg::ST_D1;
			phsr_pkg::ST_D1:  state_d = phsr_pkg::ST_D2;
			phsr_pkg::ST_D2:  state_d = phsr_pkg::ST_DS;
			phsr_pkg::ST_DS: begin
				div_start = 1'b1;
				state_d   = phsr_pkg::ST_DW;
			end
			phsr_pkg::ST_DW: begin
				if (div_done) begin
					state_d = phsr_pkg::ST_FB1;
				end
			end
			phsr_pkg::ST_FB1:   state_d = phsr_pkg::ST_FB2;
			phsr_pkg::ST_FB2:   state_d = phsr_pkg::ST_AP_RD;
			phsr_pkg::ST_AP_RD: state_d = phsr_pkg::ST_AP_Y;
			phsr_pkg::ST_AP_Y:  state_d = phsr_pkg::ST_AP_M;
			phsr_pkg::ST_AP_M:  state_d = phsr_pkg::ST_AP_WB;
			phsr_pkg::ST_AP_WB: begin
				mem_we  = 1'b1;
				state_d = (n_q == LAST_STG) ? phsr_pkg::ST_MIX1 : phsr_pkg::ST_AP_RD;
			end
			phsr_pkg::ST_MIX1: state_d = phsr_pkg::ST_MIX2;
			phsr_pkg::ST_MIX2: state_d = phsr_pkg::ST_MIX3;
			phsr_pkg::ST_MIX3: state_d = phsr_pkg::ST_MIX4;
			phsr_pkg::ST_MIX4: state_d = phsr_pkg::ST_MIX5;
			phsr_pkg::ST_MIX5: state_d = phsr_pkg::ST_FIN;
			phsr_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = phsr_pkg::ST_IDLE;
				end
			end
			default: state_d = phsr_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phsr_pkg::ST_FILL_A;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: counters, lfo phase, feedback, valid bits, output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			n_q         <= '0;
			phase_q     <= '0;
			last_q      <= '0;
			mv_q        <= '0;
			mv_rd_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mv_rd_q <= mv_q[n_q];
			if (rom_we && (k_q != N_A)) begin
				k_q <= k_q + RAW'(1);
			end
			if (accept && cfg.enabled) begin
				phase_q <= phase_q + cfg.lfo_step;
			end
			if (state_q == phsr_pkg::ST_FB2) begin
				n_q <= '0;
			end else if (mem_we) begin
				mv_q[n_q] <= 1'b1;
				if (n_q == LAST_STG) begin
					last_q <= y_q;
				end else begin
					n_q <= n_q + MAW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			phsr_pkg::ST_FILL_A: begin
				neg_q <= (a_w > {1'b0, N_A});
				q_q   <= (2*RAW)'(a_adj) * (2*RAW)'(N_A - a_adj);
			end
			phsr_pkg::ST_IDLE: begin
				sample_q <= sample_in;
				res_q    <= sample_in;
			end
			phsr_pkg::ST_ROM: begin
				frac_q <= frac_w;
				plo_q  <= cfg.delay_min * (phsr_pkg::ONE_Q16 - {1'b0, frac_w});
			end
			phsr_pkg::ST_D1: phi_q <= cfg.delay_max * frac_q;
			phsr_pkg::ST_D2: d_q <= (dsum[33:32] != 2'b00) ? 16'hFFFF : dsum[31:16];
			phsr_pkg::ST_DW: begin
				if (div_done) begin
					coef_q <= $signed({1'b0, div_quo});
				end
			end
			phsr_pkg::ST_FB1: prod_q <= last_q * $signed({1'b0, cfg.feedback_gain});
			phsr_pkg::ST_FB2: x_q <= phsr_pkg::add_sat32(x8_32, phsr_pkg::mulq16(prod_q));
			phsr_pkg::ST_AP_RD: prod_q <= x_q * coef_q;
			phsr_pkg::ST_AP_Y:  y_q <= phsr_pkg::sub_sat32(mem_val, phsr_pkg::mulq16(prod_q));
			phsr_pkg::ST_AP_M:  prod_q <= y_q * coef_q;
			phsr_pkg::ST_AP_WB: x_q <= y_q;
			phsr_pkg::ST_MIX1:  prod_q <= x8 * $signed({1'b0, w_inv});
			phsr_pkg::ST_MIX2: begin
				p1_q   <= prod_q;
				prod_q <= y_q * $signed({1'b0, w_clip});
			end
			phsr_pkg::ST_MIX3: mix_q <= mix_w[33:0];
			phsr_pkg::ST_MIX4: prod_q <= mix_q * $signed({1'b0, phsr_pkg::OUT_SCALE});
			phsr_pkg::ST_MIX5: res_q <= phsr_pkg::sat16(out_t[51:24]);
			default: ;
		endcase
		if (out_load) begin
			sample_out_q <= res_q;
		end
	end

	// sine table
	phsr_ram #(
		.WIDTH(16),
		.DEPTH(N + 1)
	) u_rom (
		.clk  (clk),
		.we   (rom_we),
		.waddr(k_q),
		.wdata(rom_wdata),
		.raddr(rom_raddr),
		.rdata(rom_rdata)
	);

	// allpass stage memory
	phsr_ram #(
		.WIDTH(32),
		.DEPTH(STAGES)
	) u_stage_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(n_q),
		.wdata(mem_wdata),
		.raddr(n_q),
		.rdata(mem_rdata)
	);

	// shared divider for table fill and coefficient
	phsr_div #(
		.NW(NW),
		.DW(DW),
		.QW(QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.numer   (div_numer),
		.denom   (div_denom),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign in_stall     = (state_q != phsr_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign sample_out   = sample_out_q;
	assign stat.filling = (state_q == phsr_pkg::ST_FILL_A) || (state_q == phsr_pkg::ST_FILL_B)
		|| (state_q == phsr_pkg::ST_FILL_W);
	assign stat.idle    = (state_q == phsr_pkg::ST_IDLE);

endmodule

[hdl/lfo_swept_allpass_phaser_top.sv]
// ---------------------------------------------------------------------------
// lfo_swept_allpass_phaser_top
// allpass phaser with a sine lfo sweep, one 16-bit sample in, one out
// ---------------------------------------------------------------------------
// After reset the block builds its sine table, one entry at a time;
// input stays stalled until the table is built, and configuration
// writes are taken at any time.
// One word is worked on at a time. While enabled, most of a word's time
// goes to the 17-step coefficient divider and to the read, modify and
// write of each allpass stage in the stage memory.
// While disabled a word passes straight from the idle state to the
// output state. A finished word waits in the output register while the
// next one is taken in.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lfo_swept_allpass_phaser_top #(
	parameter int STAGES          = 6,
	parameter int SINE_TABLE_SIZE = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [phsr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [phsr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [15:0]               sample_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [15:0]               sample_out
);

	phsr_pkg::cfg_t  cfg_q;
	phsr_pkg::stat_t stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= 1'b0;
			cfg_q.delay_min     <= phsr_pkg::RST_DELAY_MIN;
			cfg_q.delay_max     <= phsr_pkg::RST_DELAY_MAX;
			cfg_q.lfo_step      <= phsr_pkg::RST_LFO_STEP;
			cfg_q.feedback_gain <= phsr_pkg::RST_FEEDBACK_GAIN;
			cfg_q.wet_mix       <= phsr_pkg::RST_WET_MIX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				phsr_pkg::REG_ENABLED:       cfg_q.enabled       <= cfg_data[0];
				phsr_pkg::REG_DELAY_MIN:     cfg_q.delay_min     <= cfg_data[15:0];
				phsr_pkg::REG_DELAY_MAX:     cfg_q.delay_max     <= cfg_data[15:0];
				phsr_pkg::REG_LFO_STEP:      cfg_q.lfo_step      <= cfg_data[31:0];
				phsr_pkg::REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= cfg_data[15:0];
				phsr_pkg::REG_WET_MIX:       cfg_q.wet_mix       <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// sequencer with memories and divider
	phsr_core #(
		.STAGES         (STAGES),
		.SINE_TABLE_SIZE(SINE_TABLE_SIZE)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.stat      (stat)
	);

	// checks
	`PHSR_ASSERT_SAME(a_fill_stalls_input, stat.filling, in_stall)
	`PHSR_ASSERT_SAME(a_fill_no_output, stat.filling, !out_valid)
	`PHSR_ASSERT_NEXT(a_one_word_at_a_time, in_valid && !in_stall, in_stall && !stat.idle)

endmodule

[test/lfo_swept_allpass_phaser_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfo_swept_allpass_phaser_top_tb
// Self-checking bench for the allpass phaser. Audio words go in through a
// valid/stall channel while a local fixed-point phaser computes the expected
// output word; the bench walks a directed table of samples and register
// settings, then random words in phases with random register settings.
// ---------------------------------------------------------------------------
module lfo_swept_allpass_phaser_top_tb;

	localparam int NSTAGE    = 6;
	localparam int NSINE     = 256;
	localparam int CYC_LIMIT = 900000;
	localparam int DRAIN     = 200;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [phsr_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [phsr_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] sample_in;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] sample_out;

	lfo_swept_allpass_phaser_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.sample_in(sample_in), .out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out)
	);

	// phaser shadow state
	logic        m_enabled;
	logic [15:0] m_dmin, m_dmax, m_fb;
	logic [31:0] m_step, m_phase;
	logic [16:0] m_wet;
	longint      m_mem [NSTAGE];
	longint      m_coef, m_last;
	longint      sine_tab [NSINE+1];

	logic signed [15:0] expected_words [$];
	int errors, words_in, words_out, cycles;

	// directed stimulus row: register write (idx>=0) or a sample
	typedef struct {
		int          reg_idx;
		logic [31:0] value;
		logic signed [15:0] smp;
		bit          typed;
		logic signed [15:0] want;
	} row_t;
	row_t dir_rows [$];

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	function automatic longint rshift(longint v, int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint x, longint g);
		return clip32(rshift(x * g, 16));
	endfunction

	task automatic build_sine();
		longint a, q, num, den, v;
		bit neg;
		for (int k = 0; k <= NSINE; k++) begin
			a = 2 * k;
			neg = 0;
			if (a > NSINE) begin
				a -= NSINE;
				neg = 1;
			end
			if (a > NSINE) a = NSINE;
			q = a * (NSINE - a);
			num = 32767 * 16 * q;
			den = 5 * NSINE * NSINE - 4 * q;
			v = (2 * num + den) / (2 * den);
			sine_tab[k] = neg ? -v : v;
		end
	endtask

	task automatic shadow_reset();
		m_enabled = 0; m_dmin = phsr_pkg::RST_DELAY_MIN; m_dmax = phsr_pkg::RST_DELAY_MAX;
		m_step = phsr_pkg::RST_LFO_STEP; m_fb = phsr_pkg::RST_FEEDBACK_GAIN;
		m_wet = phsr_pkg::RST_WET_MIX;
		m_phase = 0; m_coef = 0; m_last = 0;
		foreach (m_mem[i]) m_mem[i] = 0;
	endtask

	function automatic logic signed [15:0] phase_sample(logic signed [15:0] s);
		longint idx, frac, d, x8, y, w, mx, o, yy;
		if (!m_enabled) return s;
		idx = ((longint'(m_phase) * NSINE) + 64'h80000000) >> 32;
		if (idx > NSINE) idx = NSINE;
		frac = sine_tab[idx] + 32768;
		m_phase = m_phase + m_step;
		d = (longint'(m_dmin) * (65536 - frac) + longint'(m_dmax) * frac + 32768) >> 16;
		if (d > 65535) d = 65535;
		m_coef = (((65536 - d) << 16) * 2 + (65536 + d)) / (2 * (65536 + d));
		x8 = longint'(s) * 256;
		y = clip32(x8 + qmul(m_last, m_fb));
		// allpass chain
		for (int n = 0; n < NSTAGE; n++) begin
			yy = clip32(m_mem[n] - qmul(y, m_coef));
			m_mem[n] = clip32(qmul(yy, m_coef) + y);
			y = yy;
		end
		m_last = y;
		w = (m_wet > 17'd65536) ? 65536 : m_wet;
		mx = rshift(x8 * (65536 - w) + y * w, 16);
		o = rshift(mx * 52429, 24);
		if (o > 32767) o = 32767;
		if (o < -32768) o = -32768;
		return 16'(o);
	endfunction

	task automatic report_mismatch(string what, logic signed [15:0] got,
		logic signed [15:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at word %0d", what, got, want,
			words_out);
	endtask

	// register write, only while idle
	task automatic write_reg(logic [phsr_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			phsr_pkg::REG_ENABLED:       m_enabled = val[0];
			phsr_pkg::REG_DELAY_MIN:     m_dmin = val[15:0];
			phsr_pkg::REG_DELAY_MAX:     m_dmax = val[15:0];
			phsr_pkg::REG_LFO_STEP:      m_step = val;
			phsr_pkg::REG_FEEDBACK_GAIN: m_fb = val[15:0];
			phsr_pkg::REG_WET_MIX:       m_wet = val[16:0];
			default: ;
		endcase
	endtask

	// drop valid, then wait until every word has left
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// send one word with random gap; returns at the falling edge after acceptance
	task automatic send_word(logic signed [15:0] s, bit typed, logic signed [15:0] want);
		logic signed [15:0] pred;
		int gap;
		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1; sample_in <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = phase_sample(s);
		if (typed && pred !== want) report_mismatch("table", pred, want);
		expected_words.push_back(typed ? want : pred);
		words_in++;
		@(negedge clk);
	endtask

	// output side: random stall per word
	initial begin
		int hold;
		out_stall = 1'b1;
		wait (arst_n);
		forever begin
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", sample_out, 16'sd0);
			end else begin
				if (sample_out !== expected_words[0])
					report_mismatch("sample_out", sample_out, expected_words[0]);
				void'(expected_words.pop_front());
			end
			words_out++;
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic row_t mk(int r, logic [31:0] v, logic signed [15:0] s, bit t,
		logic signed [15:0] w);
		row_t x;
		x.reg_idx = r; x.value = v; x.smp = s; x.typed = t; x.want = w;
		return x;
	endfunction

	initial begin
		int bursts, nwords;
		logic signed [15:0] s;
		errors = 0; words_in = 0; words_out = 0; cycles = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; sample_in = '0;
		arst_n = 0;
		build_sine();
		shadow_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// pass-through after reset, extremes typed in
		dir_rows.push_back(mk(-1, 0, 16'sh7FFF, 1, 16'sh7FFF));
		dir_rows.push_back(mk(-1, 0, 16'sh8000, 1, 16'sh8000));
		dir_rows.push_back(mk(-1, 0, 16'sh0000, 1, 16'sh0000));
		dir_rows.push_back(mk(-1, 0, -16'sd1, 1, -16'sd1));
		// enabled at reset settings
		dir_rows.push_back(mk(phsr_pkg::REG_ENABLED, 1, 0, 0, 0));
		dir_rows.push_back(mk(-1, 0, 16'sh7FFF, 0, 0));
		dir_rows.push_back(mk(-1, 0, 16'sh8000, 0, 0));
		dir_rows.push_back(mk(-1, 0, 16'sh1234, 0, 0));
		// fully dry: 0.8 of input, zero stays zero
		dir_rows.push_back(mk(phsr_pkg::REG_WET_MIX, 0, 0, 0, 0));
		dir_rows.push_back(mk(-1, 0, 16'sh0000, 0, 0));
		dir_rows.push_back(mk(-1, 0, 16'sh7FFF, 0, 0));
		// wet above one clamps to fully wet
		dir_rows.push_back(mk(phsr_pkg::REG_WET_MIX, 17'h1FFFF, 0, 0, 0));
		dir_rows.push_back(mk(-1, 0, 16'sh4000, 0, 0));
		// reversed bounds, extreme step
		dir_rows.push_back(mk(phsr_pkg::REG_DELAY_MIN, 16'hFFFF, 0, 0, 0));
		dir_rows.push_back(mk(phsr_pkg::REG_DELAY_MAX, 0, 0, 0, 0));
		dir_rows.push_back(mk(phsr_pkg::REG_LFO_STEP, 32'hFFFFFFFF, 0, 0, 0));
		dir_rows.push_back(mk(-1, 0, 16'sh8000, 0, 0));
		// runaway feedback saturates stage values
		dir_rows.push_back(mk(phsr_pkg::REG_FEEDBACK_GAIN, 16'hFFFF, 0, 0, 0));
		for (int i = 0; i < 4; i++) dir_rows.push_back(mk(-1, 0, 16'sh7FFF, 0, 0));
		// unknown register index is ignored
		dir_rows.push_back(mk(6, 32'hFFFFFFFF, 0, 0, 0));
		dir_rows.push_back(mk(7, 32'h0, 0, 0, 0));
		dir_rows.push_back(mk(-1, 0, -16'sd300, 0, 0));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].reg_idx >= 0) begin
				wait_drained();
				write_reg(dir_rows[i].reg_idx[phsr_pkg::CFG_INDEX_W-1:0], dir_rows[i].value);
			end else begin
				send_word(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// random phases with fresh settings
		bursts = 0;
		while (words_in < 1120) begin
			wait_drained();
			write_reg(phsr_pkg::REG_ENABLED, ($urandom_range(0, 5) != 0));
			write_reg(phsr_pkg::REG_DELAY_MIN,
				$urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535));
			write_reg(phsr_pkg::REG_DELAY_MAX,
				$urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 65535));
			write_reg(phsr_pkg::REG_LFO_STEP,
				$urandom_range(0, 1) ? $urandom() : $urandom_range(0, 200000));
			write_reg(phsr_pkg::REG_FEEDBACK_GAIN,
				$urandom_range(0, 3) == 0 ? 65470 : $urandom_range(0, 65535));
			write_reg(phsr_pkg::REG_WET_MIX,
				$urandom_range(0, 4) == 0 ? 65536 : $urandom_range(0, 131071));
			nwords = $urandom_range(20, 80);
			for (int k = 0; k < nwords; k++) begin
				case ($urandom_range(0, 3))
					0: s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					1: s = $signed(16'($urandom_range(0, 511))) - 16'sd256;
					default: s = 16'($urandom());
				endcase
				send_word(s, 0, 0);
			end
			bursts++;
		end

		wait_drained();
		repeat (DRAIN) @(negedge clk);
		$display("covered %0d words in, %0d words out over %0d random setting phases",
			words_in, words_out, bursts);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/phsr_pkg.sv
hdl/phsr_ram.sv
hdl/phsr_div.sv
hdl/phsr_core.sv
hdl/lfo_swept_allpass_phaser_top.sv
test/lfo_swept_allpass_phaser_top_tb.sv
